/* src/ffha_pkg.sv */
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int unsigned HeapUnits = 1024;
  localparam int unsigned IdxW = 10;
  localparam int unsigned LinkW = 11;
  localparam logic [LinkW-1:0] NullLink = 11'd1024;

  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_FREE = 2'd1,
    MARK_USED = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_SIZE = 2'd1,
    ST_NOFIT = 2'd2,
    ST_BADFREE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    CMD_IDLE = 4'd0,
    CMD_ALLOC_START = 4'd1,
    CMD_WALK_READ = 4'd2,
    CMD_WALK_EVAL = 4'd3,
    CMD_ALLOC_COMMIT = 4'd4,
    CMD_FREE_READ = 4'd5,
    CMD_FREE_EVAL = 4'd6,
    CMD_FREE_COMMIT = 4'd7,
    CMD_MERGE_READ = 4'd8,
    CMD_MERGE_COMMIT = 4'd9,
    CMD_FIX_A = 4'd10,
    CMD_FIX_B = 4'd11
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic fit;
    logic fail;
    logic bad;
    logic merge;
  } sts_t;
endpackage

/* src/ffha_if.sv */
`timescale 1ns / 1ps
interface ffha_req_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [15:0] request_bytes;
  logic [14:0] free_offset;
  modport source(output valid, opcode, request_bytes, free_offset, input ready);
  modport sink(input valid, opcode, request_bytes, free_offset, output ready);
endinterface

interface ffha_rsp_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [14:0] data_offset;
  logic [15:0] used_total_bytes;
  modport source(output valid, status, data_offset, used_total_bytes, input ready);
  modport sink(input valid, status, data_offset, used_total_bytes, output ready);
endinterface

interface ffha_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

/* src/first_fit_heap_allocator_core.sv */
`timescale 1ns / 1ps
// channel | dir  | payload
// req     | sink | opcode, request_bytes, free_offset
// rsp     | src  | status, data_offset, used_total_bytes
// cfg     | sink | data (max_request_bytes)
// Result valid at the end of a state sequence: allocate reads and checks each
// free-list block in turn, then commits and applies two link fixups, ending
// early on a rejected size or no fit; free reads, checks and commits, then
// reads the next block, merging it with fixups if free; rejects end early.
// After reset a clearing pass marks the table; no item is taken meanwhile.
// The result is held until taken; the next item is accepted from the cycle after.
module first_fit_heap_allocator_core (
  input logic clk_i,
  input logic rst_ni,
  ffha_req_if.sink req_i,
  ffha_rsp_if.source rsp_o,
  ffha_cfg_if.sink cfg_i
);
  import ffha_pkg::*;

  logic [15:0] max_q;
  ctl_t ctl;
  sts_t sts;
  logic clearing;
  logic [1:0] status;
  logic [15:0] bytes_q;
  logic [14:0] off_q;
  logic acc;

  assign cfg_i.ready = 1'b1;
  assign acc = req_i.valid && req_i.ready;

  // Hold the register and latch request fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 16'd8192;
      bytes_q <= '0; off_q <= '0;
    end else begin
      if (cfg_i.valid) max_q <= cfg_i.data;
      if (acc) begin bytes_q <= req_i.request_bytes; off_q <= req_i.free_offset; end
    end
  end

  ffha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req_i.valid), .in_op_i(req_i.opcode), .in_ready_o(req_i.ready),
    .out_valid_o(rsp_o.valid), .out_ready_i(rsp_o.ready),
    .clearing_i(clearing), .status_i(status), .sts_i(sts), .ctl_o(ctl)
  );

  ffha_datapath u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .req_bytes_i(acc ? req_i.request_bytes : bytes_q),
    .req_off_i(acc ? req_i.free_offset : off_q),
    .max_req_i(max_q), .sts_o(sts), .status_o(status),
    .data_offset_o(rsp_o.data_offset), .used_o(rsp_o.used_total_bytes),
    .busy_clear_o(clearing)
  );
  assign rsp_o.status = status;

`ifndef SYNTHESIS
  a_no_ready_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !req_i.ready) else $error("ready during clear");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid)) else $error("ready with pending result");
  a_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_OK |-> rsp_o.data_offset == 15'd0)
    else $error("offset on failure");
`endif
endmodule

/* src/ffha_datapath.sv */
`timescale 1ns / 1ps
module ffha_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  ffha_pkg::ctl_t ctl_i,
  input  logic [15:0] req_bytes_i,
  input  logic [14:0] req_off_i,
  input  logic [15:0] max_req_i,
  output ffha_pkg::sts_t sts_o,
  output logic [1:0] status_o,
  output logic [14:0] data_offset_o,
  output logic [15:0] used_o,
  output logic busy_clear_o
);
  import ffha_pkg::*;

  // Header tables
  logic [10:0] units_mem [HeapUnits];
  logic [1:0]  mark_mem  [HeapUnits];
  logic [10:0] next_mem  [HeapUnits];
  logic [10:0] prev_mem  [HeapUnits];
  logic [15:0] asked_mem [HeapUnits];

  logic [10:0] head_q;
  logic [15:0] used_cnt_q;
  logic [10:0] clr_q;
  logic [10:0] blk_q, before_q, steps_q, need_q, nb_q;
  logic [15:0] size_q;
  logic [10:0] r_units_q, r_next_q, r_prev_q;
  logic [1:0]  r_mark_q;
  logic [15:0] r_asked_q;
  logic [1:0]  status_q;
  logic [14:0] doff_q;
  // fixup queue for pending link writes
  logic        fa_q, fb_q;
  logic [10:0] fa_idx_q, fa_val_q, fb_idx_q, fb_val_q;
  logic        fa_next_q, fb_next_q;

  logic [10:0] rd_idx;
  logic [16:0] need_bytes;
  logic [10:0] need_w;
  logic [14:0] offm;

  assign need_bytes = {1'b0, req_bytes_i} + 17'd87;
  // saturate granule counts that can never fit the heap
  assign need_w = need_bytes[16] ? 11'h7FF : need_bytes[15:5];
  assign offm = req_off_i - 15'd48;
  assign busy_clear_o = clr_q != 11'd0;
  assign used_o = used_cnt_q;
  assign status_o = status_q;
  assign data_offset_o = doff_q;

  always_comb begin
    unique case (ctl_i.cmd)
      CMD_MERGE_READ: rd_idx = nb_q;
      default:        rd_idx = blk_q;
    endcase
  end

  // Registered table read
  always_ff @(posedge clk_i) begin
    if (rd_idx < 11'd1024) begin
      r_units_q <= units_mem[rd_idx[IdxW-1:0]];
      r_mark_q  <= (clr_q != 11'd0) ? MARK_NONE : mark_mem[rd_idx[IdxW-1:0]];
      r_next_q  <= next_mem[rd_idx[IdxW-1:0]];
      r_prev_q  <= prev_mem[rd_idx[IdxW-1:0]];
      r_asked_q <= asked_mem[rd_idx[IdxW-1:0]];
    end else begin
      r_mark_q <= MARK_NONE;
      r_units_q <= '0;
      r_next_q <= NullLink;
      r_prev_q <= NullLink;
      r_asked_q <= '0;
    end
  end

  logic [15:0] blk_bytes;
  logic [10:0] rest;
  assign blk_bytes = {r_units_q, 5'd0};
  assign rest = blk_q + need_q;

  always_comb begin
    sts_o.fit = r_units_q >= need_q;
    sts_o.fail = (blk_q >= 11'd1024) || (steps_q >= 11'd1024) || (r_mark_q != MARK_FREE);
    sts_o.bad = (r_mark_q != MARK_USED) || (r_units_q < 11'd2) ||
                ({1'b0, blk_q} + {1'b0, r_units_q} > 12'd1024) ||
                ({5'd0, r_asked_q} > {5'd0, blk_bytes} - 21'd56) || blk_q >= 11'd1024;
    sts_o.merge = (nb_q < 11'd1024) && (r_mark_q == MARK_FREE);
  end

  // Sequenced table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 11'd1024;
      head_q <= '0;
      used_cnt_q <= '0;
      fa_q <= 1'b0;
      fb_q <= 1'b0;
      status_q <= ST_OK;
      doff_q <= '0;
      blk_q <= '0; before_q <= NullLink; steps_q <= '0; need_q <= '0; nb_q <= '0;
      size_q <= '0;
      fa_idx_q <= '0; fa_val_q <= '0; fb_idx_q <= '0; fb_val_q <= '0;
      fa_next_q <= 1'b0; fb_next_q <= 1'b0;
    end else begin
      if (clr_q != 11'd0) begin
        clr_q <= clr_q - 11'd1;
        mark_mem[clr_q[IdxW-1:0] - 10'd1] <= (clr_q == 11'd1) ? MARK_FREE : MARK_NONE;
        if (clr_q == 11'd1) begin
          units_mem[0] <= 11'd1024;
          next_mem[0] <= NullLink;
          prev_mem[0] <= NullLink;
        end
      end
      unique case (ctl_i.cmd)
        CMD_ALLOC_START: begin
          blk_q <= head_q; before_q <= NullLink; steps_q <= '0;
          need_q <= need_w; size_q <= req_bytes_i;
          doff_q <= '0;
          if (req_bytes_i == 16'd0 || req_bytes_i > max_req_i) status_q <= ST_SIZE;
          else status_q <= ST_OK;
        end
        CMD_WALK_EVAL: begin
          if (sts_o.fail) status_q <= ST_NOFIT;
          else if (!sts_o.fit) begin
            before_q <= blk_q; blk_q <= r_next_q; steps_q <= steps_q + 11'd1;
          end
        end
        CMD_ALLOC_COMMIT: begin
          logic [10:0] after, units;
          if (blk_bytes >= {need_q, 5'd0} + 16'd80 && rest < 11'd1024) begin
            units_mem[rest[IdxW-1:0]] <= r_units_q - need_q;
            mark_mem[rest[IdxW-1:0]] <= MARK_FREE;
            asked_mem[rest[IdxW-1:0]] <= '0;
            next_mem[rest[IdxW-1:0]] <= r_next_q;
            prev_mem[rest[IdxW-1:0]] <= blk_q;
            after = rest; units = need_q;
            units_mem[blk_q[IdxW-1:0]] <= need_q;
            // rest's old-next prev -> rest; after's prev -> before
            fa_q <= 1'b1; fa_next_q <= 1'b0; fa_idx_q <= r_next_q; fa_val_q <= rest;
          end else begin
            after = r_next_q; units = r_units_q;
            fa_q <= 1'b0;
          end
          if (before_q < 11'd1024) begin
            fb_q <= 1'b1; fb_next_q <= 1'b1; fb_idx_q <= before_q; fb_val_q <= after;
          end else begin
            head_q <= after; fb_q <= 1'b0;
          end
          if (after == rest && blk_bytes >= {need_q, 5'd0} + 16'd80 && rest < 11'd1024)
            prev_mem[rest[IdxW-1:0]] <= before_q;
          else if (after < 11'd1024) prev_mem[after[IdxW-1:0]] <= before_q;
          mark_mem[blk_q[IdxW-1:0]] <= MARK_USED;
          asked_mem[blk_q[IdxW-1:0]] <= size_q;
          next_mem[blk_q[IdxW-1:0]] <= NullLink;
          used_cnt_q <= used_cnt_q + {units, 5'd0};
          doff_q <= {blk_q[9:0], 5'd0} + 15'd48;
        end
        CMD_FREE_READ: begin
          blk_q <= {1'b0, offm[14:5]};
          doff_q <= '0;
          if (req_off_i < 15'd48 || offm[4:0] != 5'd0) begin
            status_q <= ST_BADFREE; blk_q <= 11'd1024;
          end else status_q <= ST_OK;
        end
        CMD_FREE_EVAL: begin
          if (sts_o.bad) status_q <= ST_BADFREE;
          nb_q <= blk_q + r_units_q;
          need_q <= r_units_q;
        end
        CMD_FREE_COMMIT: begin
          used_cnt_q <= used_cnt_q - {need_q, 5'd0};
          mark_mem[blk_q[IdxW-1:0]] <= MARK_FREE;
          asked_mem[blk_q[IdxW-1:0]] <= '0;
          next_mem[blk_q[IdxW-1:0]] <= head_q;
          prev_mem[blk_q[IdxW-1:0]] <= NullLink;
          if (head_q < 11'd1024) prev_mem[head_q[IdxW-1:0]] <= blk_q;
          head_q <= blk_q;
        end
        CMD_MERGE_COMMIT: begin
          // r_* now hold nb after the free commit
          fa_q <= 1'b0; fb_q <= 1'b0;
          if (r_prev_q < 11'd1024) begin
            fb_q <= 1'b1; fb_next_q <= 1'b1; fb_idx_q <= r_prev_q; fb_val_q <= r_next_q;
          end else head_q <= r_next_q;
          if (r_next_q < 11'd1024) begin
            fa_q <= 1'b1; fa_next_q <= 1'b0; fa_idx_q <= r_next_q; fa_val_q <= r_prev_q;
          end
          units_mem[blk_q[IdxW-1:0]] <= need_q + r_units_q;
          mark_mem[nb_q[IdxW-1:0]] <= MARK_NONE;
          asked_mem[nb_q[IdxW-1:0]] <= '0;
        end
        CMD_FIX_A: begin
          if (fa_q && fa_idx_q < 11'd1024) begin
            if (fa_next_q) next_mem[fa_idx_q[IdxW-1:0]] <= fa_val_q;
            else prev_mem[fa_idx_q[IdxW-1:0]] <= fa_val_q;
          end
          fa_q <= 1'b0;
        end
        CMD_FIX_B: begin
          if (fb_q && fb_idx_q < 11'd1024) begin
            if (fb_next_q) next_mem[fb_idx_q[IdxW-1:0]] <= fb_val_q;
            else prev_mem[fb_idx_q[IdxW-1:0]] <= fb_val_q;
          end
          fb_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

/* src/ffha_ctrl.sv */
`timescale 1ns / 1ps
module ffha_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_op_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  logic clearing_i,
  input  logic [1:0] status_i,
  input  ffha_pkg::sts_t sts_i,
  output ffha_pkg::ctl_t ctl_o
);
  import ffha_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_WREAD  = 12'b000000000010,
    S_WEVAL  = 12'b000000000100,
    S_ACOMM  = 12'b000000001000,
    S_FREAD  = 12'b000000010000,
    S_FEVAL  = 12'b000000100000,
    S_FCOMM  = 12'b000001000000,
    S_MREAD  = 12'b000010000000,
    S_MCOMM  = 12'b000100000000,
    S_FIXA   = 12'b001000000000,
    S_FIXB   = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && !clearing_i;
  assign out_valid_o = (state_q == S_DONE);

  always_comb begin
    state_d = state_q;
    ctl_o.cmd = CMD_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (in_op_i) begin ctl_o.cmd = CMD_FREE_READ; state_d = S_FREAD; end
          else begin ctl_o.cmd = CMD_ALLOC_START; state_d = S_WREAD; end
        end
      end
      S_WREAD: begin
        ctl_o.cmd = CMD_WALK_READ;
        state_d = (status_i != ST_OK) ? S_DONE : S_WEVAL;
      end
      S_WEVAL: begin
        ctl_o.cmd = CMD_WALK_EVAL;
        if (sts_i.fail) state_d = S_DONE;
        else if (sts_i.fit) state_d = S_ACOMM;
        else state_d = S_WREAD;
      end
      S_ACOMM: begin ctl_o.cmd = CMD_ALLOC_COMMIT; state_d = S_FIXA; end
      S_FREAD: begin
        ctl_o.cmd = CMD_WALK_READ;
        state_d = (status_i != ST_OK) ? S_DONE : S_FEVAL;
      end
      S_FEVAL: begin
        ctl_o.cmd = CMD_FREE_EVAL;
        state_d = sts_i.bad ? S_DONE : S_FCOMM;
      end
      S_FCOMM: begin ctl_o.cmd = CMD_FREE_COMMIT; state_d = S_MREAD; end
      S_MREAD: begin ctl_o.cmd = CMD_MERGE_READ; state_d = S_MCOMM; end
      S_MCOMM: begin
        if (sts_i.merge) begin ctl_o.cmd = CMD_MERGE_COMMIT; state_d = S_FIXA; end
        else state_d = S_DONE;
      end
      S_FIXA: begin ctl_o.cmd = CMD_FIX_A; state_d = S_FIXB; end
      S_FIXB: begin ctl_o.cmd = CMD_FIX_B; state_d = S_DONE; end
      S_DONE: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

/* test/ffha_checker.sv */
`timescale 1ns / 1ps
module ffha_checker (
  input logic clk_i,
  input logic rst_ni,
  ffha_req_if req,
  ffha_rsp_if rsp,
  ffha_cfg_if cfg,
  output int unsigned outstanding_o,
  output int unsigned errors_o
);
  import ffha_pkg::*;

  typedef struct {
    status_e st;
    logic [14:0] offset;
    logic [15:0] used;
  } alloc_result_t;

  // shadow header table
  logic [10:0] blk_units[HeapUnits];
  mark_e blk_mark[HeapUnits];
  logic [10:0] nxt_link[HeapUnits];
  logic [10:0] prv_link[HeapUnits];
  logic [15:0] blk_asked[HeapUnits];
  logic [10:0] list_head;
  logic [15:0] used_bytes;
  logic [15:0] size_limit;
  alloc_result_t pending_results[$];
  int unsigned errors;

  assign outstanding_o = pending_results.size();
  assign errors_o = errors;

  task automatic clear_heap();
    for (int i = 0; i < HeapUnits; i++) begin
      blk_units[i] = '0;
      blk_mark[i] = MARK_NONE;
      nxt_link[i] = NullLink;
      prv_link[i] = NullLink;
      blk_asked[i] = '0;
    end
    blk_units[0] = 11'd1024;
    blk_mark[0] = MARK_FREE;
    list_head = '0;
    used_bytes = '0;
    size_limit = 16'd8192;
  endtask

  // first-fit walk, split, unlink
  function automatic status_e take_block(input int size, output logic [14:0] offset);
    int blk, prior, steps, need, after, rest;
    blk = list_head;
    prior = HeapUnits;
    steps = 0;
    offset = '0;
    if (size == 0 || size > size_limit) return ST_SIZE;
    need = (size + 56 + 31) / 32;
    forever begin
      if (blk >= HeapUnits || steps >= HeapUnits) return ST_NOFIT;
      if (blk_mark[blk] != MARK_FREE) return ST_NOFIT;
      if (blk_units[blk] >= need) break;
      prior = blk;
      blk = nxt_link[blk];
      steps++;
    end
    if (blk_units[blk] * 32 >= need * 32 + 80) begin
      rest = blk + need;
      if (rest < HeapUnits) begin
        blk_units[rest] = 11'(blk_units[blk] - need);
        blk_mark[rest] = MARK_FREE;
        blk_asked[rest] = '0;
        nxt_link[rest] = nxt_link[blk];
        prv_link[rest] = 11'(blk);
        if (nxt_link[blk] < HeapUnits) prv_link[nxt_link[blk]] = 11'(rest);
        blk_units[blk] = 11'(need);
        nxt_link[blk] = 11'(rest);
      end
    end
    after = nxt_link[blk];
    if (prior < HeapUnits) nxt_link[prior] = 11'(after);
    else list_head = 11'(after);
    if (after < HeapUnits) prv_link[after] = 11'(prior);
    blk_mark[blk] = MARK_USED;
    blk_asked[blk] = 16'(size);
    nxt_link[blk] = NullLink;
    used_bytes = used_bytes + 16'(blk_units[blk] * 32);
    offset = 15'(blk * 32 + 48);
    return ST_OK;
  endfunction

  // validate, push on list head, merge with the next physical block
  function automatic status_e release_block(input int off);
    int blk, nb, p, n, bytes;
    if (off < 48 || (off - 48) % 32 != 0) return ST_BADFREE;
    blk = (off - 48) / 32;
    if (blk >= HeapUnits || blk_mark[blk] != MARK_USED) return ST_BADFREE;
    bytes = blk_units[blk] * 32;
    if (bytes < 56 || blk + blk_units[blk] > HeapUnits) return ST_BADFREE;
    if (blk_asked[blk] > bytes - 56) return ST_BADFREE;
    used_bytes = used_bytes - 16'(bytes);
    blk_mark[blk] = MARK_FREE;
    blk_asked[blk] = '0;
    nxt_link[blk] = list_head;
    prv_link[blk] = NullLink;
    if (list_head < HeapUnits) prv_link[list_head] = 11'(blk);
    list_head = 11'(blk);
    nb = blk + blk_units[blk];
    if (nb < HeapUnits && blk_mark[nb] == MARK_FREE) begin
      p = prv_link[nb];
      n = nxt_link[nb];
      if (p < HeapUnits) nxt_link[p] = 11'(n);
      else list_head = 11'(n);
      if (n < HeapUnits) prv_link[n] = 11'(p);
      blk_units[blk] = 11'(blk_units[blk] + blk_units[nb]);
      blk_mark[nb] = MARK_NONE;
      blk_asked[nb] = '0;
    end
    return ST_OK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t exp_res, got;
    if (!rst_ni) begin
      clear_heap();
      pending_results.delete();
      errors = 0;
    end else begin
      // track the limit register
      if (cfg.valid && cfg.ready) size_limit = cfg.data;
      // predict each accepted item
      if (req.valid && req.ready) begin
        exp_res.offset = '0;
        if (req.opcode == 1'b0) exp_res.st = take_block(req.request_bytes, exp_res.offset);
        else exp_res.st = release_block(req.free_offset);
        exp_res.used = used_bytes;
        pending_results.push_back(exp_res);
      end
      // compare each result with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d", rsp.status);
          errors++;
        end else begin
          got = pending_results.pop_front();
          if (rsp.status !== got.st) begin
            $error("status: expected %0d, actual %0d", got.st, rsp.status);
            errors++;
          end
          if (rsp.data_offset !== got.offset) begin
            $error("data_offset: expected %0d, actual %0d", got.offset, rsp.data_offset);
            errors++;
          end
          if (rsp.used_total_bytes !== got.used) begin
            $error("used_total_bytes: expected %0d, actual %0d", got.used,
                   rsp.used_total_bytes);
            errors++;
          end
        end
      end
    end
  end
endmodule

/* test/first_fit_heap_allocator_core_tb.sv */
`timescale 1ns / 1ps
module first_fit_heap_allocator_core_tb;
  import ffha_pkg::*;

  logic clk;
  logic rst_n;
  int unsigned outstanding;
  int unsigned errors;
  int idle_pct;
  int stall_pct;
  int hold_left;
  bit long_hold_go;
  logic sent_ops[$];
  int live_offsets[$];

  ffha_req_if req();
  ffha_rsp_if rsp();
  ffha_cfg_if cfg();

  first_fit_heap_allocator_core dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .req_i(req),
    .rsp_o(rsp),
    .cfg_i(cfg)
  );

  ffha_checker heap_check (
    .clk_i(clk),
    .rst_ni(rst_n),
    .req(req),
    .rsp(rsp),
    .cfg(cfg),
    .outstanding_o(outstanding),
    .errors_o(errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stall the result side; a long hold is counted here
  always @(posedge clk) begin
    if (long_hold_go) begin
      hold_left = 400;
      long_hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // record successful allocations so that later frees can name them
  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready && sent_ops.size() > 0) begin
      if (sent_ops.pop_front() == 1'b0 && rsp.status == ST_OK)
        live_offsets.push_back(rsp.data_offset);
    end
  end

  task automatic send_item(input logic op, input int bytes, input int offset);
    logic rdy;
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.request_bytes <= 16'(bytes);
    req.free_offset <= 15'(offset);
    do begin
      @(negedge clk);
      rdy = req.ready;
      @(posedge clk);
    end while (!rdy);
    sent_ops.push_back(op);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input int value);
    logic rdy;
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= 16'(value);
    do begin
      @(negedge clk);
      rdy = cfg.ready;
      @(posedge clk);
    end while (!rdy);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic free_live();
    int k;
    k = $urandom_range(live_offsets.size() - 1);
    send_item(1'b1, $urandom, live_offsets[k]);
    live_offsets.delete(k);
  endtask

  // mostly well-formed alloc/free traffic, some oversized and junk items
  task automatic random_items(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45 && live_offsets.size() > 0) free_live();
      else if (pick < 52) send_item(1'b1, $urandom, $urandom);
      else if (pick < 60) send_item(1'b0, $urandom_range(0, 32768), $urandom);
      else if (pick < 63) send_item(1'b0, 0, $urandom);
      else send_item(1'b0, $urandom_range(1, 700), $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    long_hold_go = 1'b0;
    req.valid = 1'b0;
    req.opcode = 1'b0;
    req.request_bytes = '0;
    req.free_offset = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size limits, bad offsets, double free, no fit
    send_item(1'b0, 0, 0);
    send_item(1'b0, 1, 0);
    send_item(1'b0, 8192, 0);
    send_item(1'b0, 8193, 0);
    send_item(1'b0, 32768, 0);
    send_item(1'b0, 8000, 0);
    send_item(1'b0, 8000, 0);
    send_item(1'b0, 8000, 0);
    send_item(1'b1, 0, 0);
    send_item(1'b1, 0, 47);
    send_item(1'b1, 0, 49);
    send_item(1'b1, 0, 32767);
    send_item(1'b1, 0, 32752);
    send_item(1'b1, 0, 48);
    send_item(1'b1, 0, 48);
    send_item(1'b1, 0, 80);
    drain();
    while (live_offsets.size() > 0) free_live();
    write_limit(32768);
    send_item(1'b0, 32768, 0);
    send_item(1'b0, 32000, 0);
    send_item(1'b0, 32000, 0);
    send_item(1'b1, 0, 48);

    // phase: no idling, with one long receiver hold
    random_items(40);
    long_hold_go = 1'b1;
    random_items(60);

    write_limit(1);
    send_item(1'b0, 1, 0);
    send_item(1'b0, 2, 0);
    random_items(15);

    write_limit(0);
    send_item(1'b0, 1, 0);
    random_items(15);

    // phase: sender idle
    write_limit(16383);
    idle_pct = 56;
    random_items(50);
    drain();
    random_items(50);

    // phase: receiver stalling
    write_limit(4096);
    idle_pct = 0;
    stall_pct = 56;
    random_items(100);

    // phase: both idle
    write_limit(8192);
    idle_pct = 27;
    stall_pct = 27;
    random_items(100);

    drain();
    if (errors == 0) $display("first_fit_heap_allocator_core_tb OK");
    else $display("first_fit_heap_allocator_core_tb NOT OK");
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("first_fit_heap_allocator_core_tb NOT OK");
    $finish;
  end
endmodule
